// ===== src/tpa_pkg.sv =====
// shared types and constants for the triangle primitive assembler
package tpa_pkg;

   // field widths of the item payloads
   localparam int VERTEX_ID_WIDTH = 16;
   localparam int PRIM_KIND_WIDTH = 2;

   // default number of vertex index bits in use
   localparam int VERTEX_ID_BITS_DEFAULT = 16;

   // primitive kind codes
   typedef enum logic [PRIM_KIND_WIDTH-1:0] {
      KIND_SEPARATE = 2'd0,
      KIND_STRIP    = 2'd1,
      KIND_FAN      = 2'd2
   } prim_kind_type;

   // one incoming vertex item
   typedef struct packed {
      logic [VERTEX_ID_WIDTH-1:0] vertex_id;
      logic [PRIM_KIND_WIDTH-1:0] prim_kind;
      logic                       starts_primitive;
   } req_type;

   // one emitted triangle item
   typedef struct packed {
      logic [VERTEX_ID_WIDTH-1:0] corner_a;
      logic [VERTEX_ID_WIDTH-1:0] corner_b;
      logic [VERTEX_ID_WIDTH-1:0] corner_c;
   } rsp_type;

endpackage

// ===== src/tpa_core.sv =====
// vertex history, position counters and triangle formation for one vertex item
module tpa_core import tpa_pkg::*; #(
   parameter int VERTEX_ID_BITS = VERTEX_ID_BITS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    keep_strip_order,
   input  logic    accept,
   input  req_type req,
   output logic    tri_valid,
   output rsp_type tri_data
);

   // stored index width: ids wider than the payload field gain nothing
   localparam int ID_W = (VERTEX_ID_BITS < VERTEX_ID_WIDTH) ? VERTEX_ID_BITS : VERTEX_ID_WIDTH;

   function automatic logic is_degenerate(input logic [ID_W-1:0] a,
                                          input logic [ID_W-1:0] b,
                                          input logic [ID_W-1:0] c);
      return (a == b) || (b == c) || (a == c);
   endfunction

   logic [PRIM_KIND_WIDTH-1:0] kind_ff, kind_in;
   logic [ID_W-1:0]            anchor_ff, older_ff, newer_ff;
   logic [1:0]                 seen_ff, seen_in, seen_eff;
   logic [1:0]                 phase_ff, phase_in, phase_eff;
   logic                       parity_ff, parity_in, parity_eff;
   logic [ID_W-1:0]            vtx;
   logic [ID_W-1:0]            a_sel, b_sel;
   logic                       emit;

   // a primitive start clears the counters before the vertex is used
   always_comb begin
      vtx        = req.vertex_id[ID_W-1:0];
      kind_in    = req.starts_primitive ? req.prim_kind : kind_ff;
      seen_eff   = req.starts_primitive ? 2'd0 : seen_ff;
      phase_eff  = req.starts_primitive ? 2'd0 : phase_ff;
      parity_eff = req.starts_primitive ? 1'b0 : parity_ff;
      seen_in    = (seen_eff < 2'd2) ? seen_eff + 2'd1 : seen_eff;
   end

   // triangle selection by primitive kind, latched or taken from a starting item
   always_comb begin
      emit      = 1'b0;
      a_sel     = older_ff;
      b_sel     = newer_ff;
      phase_in  = phase_eff;
      parity_in = parity_eff;
      unique case (kind_in)
         KIND_SEPARATE: begin
            if (phase_eff >= 2'd2) begin
               emit     = !is_degenerate(older_ff, newer_ff, vtx);
               phase_in = 2'd0;
            end else begin
               phase_in = phase_eff + 2'd1;
            end
         end
         KIND_STRIP: begin
            if (seen_eff >= 2'd2) begin
               emit      = !is_degenerate(older_ff, newer_ff, vtx);
               parity_in = ~parity_eff;
               if (parity_eff && !keep_strip_order) begin
                  a_sel = newer_ff;
                  b_sel = older_ff;
               end
            end
         end
         KIND_FAN: begin
            if (seen_eff >= 2'd2) begin
               emit  = !is_degenerate(anchor_ff, newer_ff, vtx);
               a_sel = anchor_ff;
            end
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   assign tri_valid         = accept && emit;
   assign tri_data.corner_a = VERTEX_ID_WIDTH'(a_sel);
   assign tri_data.corner_b = VERTEX_ID_WIDTH'(b_sel);
   assign tri_data.corner_c = VERTEX_ID_WIDTH'(vtx);

   // assembly state
   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff   <= KIND_SEPARATE;
         seen_ff   <= 2'd0;
         phase_ff  <= 2'd0;
         parity_ff <= 1'b0;
         anchor_ff <= '0;
         older_ff  <= '0;
         newer_ff  <= '0;
      end else if (accept) begin
         kind_ff   <= kind_in;
         seen_ff   <= seen_in;
         phase_ff  <= phase_in;
         parity_ff <= parity_in;
         if (seen_eff == 2'd0) begin
            anchor_ff <= vtx;
         end
         older_ff <= newer_ff;
         newer_ff <= vtx;
      end
   end

endmodule

// ===== src/triangle_primitive_assembler_unit.sv =====
// top level of the triangle primitive assembler: channels, register and result buffering
//
// Takes one vertex item per cycle while req_stall is low on the req_ channel
// (valid/stall) and emits assembled triangles on the rsp_ channel (valid/stall).
// An item is taken at a clock edge where req_valid is high and req_stall is low.
// Each vertex item yields zero or one triangle; a triangle is registered in the
// result register, or in the skid buffer while the receiver stalls, before rsp_valid shows it.
// Throughput is one vertex item per cycle while the skid buffer is empty: the
// assembly state updates in a single pass, and the result register plus a
// one-entry skid buffer let the next item enter while a finished triangle waits.
// When the receiver stalls, the held triangle stays on rsp_payload; a second
// triangle goes into the skid buffer, and req_stall then rises until the
// skid buffer drains.
// The keep_strip_order register is written through csr_valid/csr_ready (always ready);
// the user must write it only while the block is idle, and the block does not enforce this.
// Synchronous reset clears the assembly state, the register and both result
// buffers; the stream is treated as separate triangles until a primitive start.
module triangle_primitive_assembler_unit import tpa_pkg::*; #(
   parameter int VERTEX_ID_BITS = VERTEX_ID_BITS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload,
   input  logic    csr_valid,
   output logic    csr_ready,
   input  logic    csr_data
);

   logic    keep_ff;
   logic    out_valid_ff, skid_valid_ff;
   rsp_type out_data_ff, skid_data_ff;
   logic    req_accept, rsp_fire;
   logic    tri_valid;
   rsp_type tri_data;

   assign csr_ready  = 1'b1;
   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid && !req_stall;
   assign rsp_fire   = out_valid_ff && !rsp_stall;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         keep_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         keep_ff <= csr_data;
      end
   end

   tpa_core #(
      .VERTEX_ID_BITS(VERTEX_ID_BITS)
   ) u_core (
      .clock           (clock),
      .reset           (reset),
      .keep_strip_order(keep_ff),
      .accept          (req_accept),
      .req             (req_payload),
      .tri_valid       (tri_valid),
      .tri_data        (tri_data)
   );

   // result register and skid buffer
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_fire) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (!out_valid_ff || rsp_fire) begin
         out_valid_ff <= tri_valid;
      end else if (tri_valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   // result payloads
   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_fire) begin
            out_data_ff <= skid_data_ff;
         end
      end else if (!out_valid_ff || rsp_fire) begin
         if (tri_valid) begin
            out_data_ff <= tri_data;
         end
      end else if (tri_valid) begin
         skid_data_ff <= tri_data;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_data_ff;

endmodule
